// File: rtl/vlpb_pkg.sv
// Shared types, register codes and color helpers for the palette/blur line block.
// No dependencies; imported by the top level, the checker and the testbench.
`timescale 1ns / 1ps

package vlpb_pkg;

  localparam int COLOR_BITS_DEF = 15;   // default palette index width per bank
  localparam int INDEX_W        = 15;   // width of index fields on the item channel
  localparam int COLOR_W        = 32;   // ARGB word
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PALETTE_SELECT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCANLINE_ENABLE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLUR_ENABLE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTERLACE_MODE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FIELD_ODD       = 3'd4;

  // item opcodes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  localparam logic [COLOR_W-1:0] RGB_HALF_MASK = 32'h00fe_fefe;
  localparam logic [COLOR_W-1:0] ALPHA_OPAQUE  = 32'hff00_0000;
  localparam logic [COLOR_W-1:0] BYTE_LSB_MASK = 32'h0101_0101;

  typedef struct packed {
    logic               op;
    logic               load_bank;
    logic [INDEX_W-1:0] load_index;
    logic [COLOR_W-1:0] load_color;
    logic [INDEX_W-1:0] pixel_upper;
    logic [INDEX_W-1:0] pixel_lower;
    logic               end_of_row;
  } item_t;

  typedef struct packed {
    logic [COLOR_W-1:0] upper_color;
    logic [COLOR_W-1:0] lower_color;
    logic               row_done;
  } result_t;

  // scanline darkening: halve RGB, drop the carry bits, force alpha opaque
  function automatic logic [COLOR_W-1:0] darken(input logic [COLOR_W-1:0] c);
    return ALPHA_OPAQUE | ((c & RGB_HALF_MASK) >> 1);
  endfunction

  // per-byte floor average without carries crossing byte lanes
  function automatic logic [COLOR_W-1:0] avg_bytes(input logic [COLOR_W-1:0] a,
                                                    input logic [COLOR_W-1:0] b);
    return (a & b) + (((a ^ b) & ~BYTE_LSB_MASK) >> 1);
  endfunction

endpackage

// File: rtl/vlpb_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module vlpb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/video_line_palette_blur.sv
// Top level: palette lookup, scanline darkening and horizontal blur for two lines.
// Depends on vlpb_pkg and vlpb_ram.
`timescale 1ns / 1ps
//
//  channel   direction  handshake                 payload
//  item      in         item_valid / item_ready   item   (item_t: load or pixel pair)
//  result    out        result_valid/result_ready result (result_t: two colors, row_done)
//  cfg       in         cfg_we (no wait)          cfg_index, cfg_data
//
//  Pixel pairs flow at one per cycle while the result channel does not stall:
//  lookup in the palette RAMs, then darken/blur into the result register.
//  A row end with a held pair emits two results, one after the other, from
//  the output stage. Palette loads give no result.
//  rst (synchronous) clears the pipeline valids, the held flag and the
//  configuration registers; palette contents are undefined until loaded.
//  A stalled result register backs up into the lookup stage, which then
//  drops item_ready.

module video_line_palette_blur
  import vlpb_pkg::*;
#(
  parameter int COLOR_BITS = COLOR_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  item_t                 item,
  output logic                  result_valid,
  input  logic                  result_ready,
  output result_t               result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // bank bit on top of the masked index
  localparam int ADDR_W = COLOR_BITS + 1;
  localparam int DEPTH  = 2 ** ADDR_W;

  // configuration registers
  logic palette_select;
  logic scanline_enable;
  logic blur_enable;
  logic interlace_mode;
  logic field_odd;

  // lookup stage
  logic s1_valid;
  logic s1_eor;

  // pair held back for the blur
  logic               held_valid;
  logic [COLOR_W-1:0] held_upper;
  logic [COLOR_W-1:0] held_lower;

  logic               accept;
  logic               pix_accept;
  logic               load_accept;
  logic [ADDR_W-1:0]  waddr;
  logic [ADDR_W-1:0]  raddr_upper;
  logic [ADDR_W-1:0]  raddr_lower;
  logic [COLOR_W-1:0] rdata_upper;
  logic [COLOR_W-1:0] rdata_lower;

  logic [COLOR_W-1:0] cur_upper;
  logic [COLOR_W-1:0] cur_lower;
  logic               slot_free;
  logic               step;
  logic               hold_cur;
  logic               emit;
  logic               s1_done;
  result_t            emit_data;

  assign accept      = item_valid && item_ready;
  assign pix_accept  = accept && (item.op == OP_PIXEL);
  assign load_accept = accept && (item.op == OP_LOAD);

  // Loads write at their transfer edge, so any later pixel reads the new word.
  assign waddr       = {item.load_bank, COLOR_BITS'(item.load_index)};
  assign raddr_upper = {palette_select, COLOR_BITS'(item.pixel_upper)};
  assign raddr_lower = {palette_select, COLOR_BITS'(item.pixel_lower)};

  // Two copies of the palette, one read port each.
  vlpb_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (DEPTH)
  ) u_pal_upper (
    .clk   (clk),
    .we    (load_accept),
    .waddr (waddr),
    .wdata (item.load_color),
    .re    (pix_accept),
    .raddr (raddr_upper),
    .rdata (rdata_upper)
  );

  vlpb_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (DEPTH)
  ) u_pal_lower (
    .clk   (clk),
    .we    (load_accept),
    .waddr (waddr),
    .wdata (item.load_color),
    .re    (pix_accept),
    .raddr (raddr_lower),
    .rdata (rdata_lower)
  );

  // Line colors after scanline darkening. Read data holds while stalled,
  // since the RAMs only read on a pixel transfer.
  always_comb begin
    cur_upper = rdata_upper;
    cur_lower = interlace_mode ? rdata_lower : rdata_upper;
    if (scanline_enable) begin
      if (interlace_mode && field_odd) begin
        cur_upper = darken(cur_upper);
      end else begin
        cur_lower = darken(cur_lower);
      end
    end
  end

  // Output stage: one result per cycle while the result register is free.
  //  held pair present -> emit it blurred with the current pair; then either
  //                       hold the current pair (done) or emit it on the next step.
  //  nothing held      -> hold the current pair, or emit it as is.
  assign slot_free = !result_valid || result_ready;
  assign step      = s1_valid && slot_free;
  assign hold_cur  = blur_enable && !s1_eor;
  assign emit      = step && (held_valid || !hold_cur);
  assign s1_done   = step && (!held_valid || hold_cur);
  assign item_ready = !s1_valid || s1_done;

  always_comb begin
    if (held_valid) begin
      emit_data.upper_color = avg_bytes(held_upper, cur_upper);
      emit_data.lower_color = avg_bytes(held_lower, cur_lower);
      emit_data.row_done    = 1'b0;
    end else begin
      emit_data.upper_color = cur_upper;
      emit_data.lower_color = cur_lower;
      emit_data.row_done    = s1_eor;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      palette_select  <= 1'b0;
      scanline_enable <= 1'b0;
      blur_enable     <= 1'b0;
      interlace_mode  <= 1'b0;
      field_odd       <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PALETTE_SELECT:  palette_select  <= cfg_data[0];
        REG_SCANLINE_ENABLE: scanline_enable <= cfg_data[0];
        REG_BLUR_ENABLE:     blur_enable     <= cfg_data[0];
        REG_INTERLACE_MODE:  interlace_mode  <= cfg_data[0];
        REG_FIELD_ODD:       field_odd       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      held_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (pix_accept) begin
        s1_valid <= 1'b1;
      end else if (s1_done) begin
        s1_valid <= 1'b0;
      end

      if (step) begin
        held_valid <= hold_cur;
      end

      if (emit) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (pix_accept) begin
      s1_eor <= item.end_of_row;
    end
    if (step && hold_cur) begin
      held_upper <= cur_upper;
      held_lower <= cur_lower;
    end
    if (emit) begin
      result <= emit_data;
    end
  end

endmodule

// File: rtl/vlpb_checker.sv
// Port-level assertions for the palette/blur line block, bound to its top level.
// Depends on vlpb_pkg and video_line_palette_blur.
`timescale 1ns / 1ps

module vlpb_checker
  import vlpb_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    item_valid,
  input logic    item_ready,
  input logic    result_valid,
  input logic    result_ready,
  input result_t result
);

  // a result waiting on the sink keeps its value
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed or dropped while stalled");

  // reset empties the result register
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

  // input backpressure only comes from a pending or just-issued result
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !item_ready |=> result_valid)
    else $error("item_ready low with no result behind it");

  // an offered item stays offered until its transfer
  a_item_hold: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_ready |=> item_valid)
    else $error("item_valid dropped before the transfer");

endmodule

bind video_line_palette_blur vlpb_checker u_vlpb_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

// File: dv/video_line_palette_blur_tb.sv
// Self-checking testbench for video_line_palette_blur: palette loads, scanline dimming,
// interlace line choice and horizontal blur, checked against an in-bench predictor.
// Depends on vlpb_pkg and the video_line_palette_blur RTL.
`timescale 1ns / 1ps

module video_line_palette_blur_tb
  import vlpb_pkg::*;
;

  // Slowest legal run: ~1830 items, each with an 85% sender gap or up to two
  // results behind an 85% receiver stall, plus settle pauses at every
  // reconfiguration; the limit leaves plenty of margin for long random stall runs.
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 8;    // covers lookup + output stage after the last result
  localparam int RANDOM_ITEMS  = 600;  // per idling phase, three phases
  localparam int BANK_DEPTH    = 1 << COLOR_BITS_DEF;

  logic                  clk;
  logic                  rst;
  logic                  item_valid;
  logic                  item_ready;
  item_t                 item;
  logic                  result_valid;
  logic                  result_ready;
  result_t               result;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  video_line_palette_blur dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: shadow palette, written-entry bookkeeping, held blur pair
  // and a copy of the registers.
  // ---------------------------------------------------------------------------
  logic [COLOR_W-1:0] shadow_palette [2][BANK_DEPTH];
  bit                 entry_written  [2][BANK_DEPTH];
  // Only written entries are ever looked up; these lists feed the index picker.
  logic [INDEX_W-1:0] bank0_entries[$];
  logic [INDEX_W-1:0] bank1_entries[$];

  logic [COLOR_W-1:0] held_up_color;
  logic [COLOR_W-1:0] held_lo_color;
  bit                 held_pair;

  bit sel_bank;
  bit scan_on;
  bit blur_on;
  bit interlaced;
  bit odd_field;

  result_t expected_pixels[$];
  result_t next_expected;

  int mismatches;
  int items_sent;
  int cycle_count;
  int send_idle_pct;
  int recv_idle_pct;

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Color arithmetic of the predictor
  // ---------------------------------------------------------------------------
  // Scanline dimming: each RGB byte shifted down by one, alpha forced opaque.
  function automatic logic [COLOR_W-1:0] dim_rgb(logic [COLOR_W-1:0] c);
    logic [COLOR_W-1:0] r;
    r[31:24] = 8'hff;
    for (int b = 0; b < 3; b++) r[8*b +: 8] = {1'b0, c[8*b+1 +: 7]};
    return r;
  endfunction

  // Floor average per byte lane, no carry between lanes.
  function automatic logic [COLOR_W-1:0] blend_bytes(logic [COLOR_W-1:0] a,
                                                      logic [COLOR_W-1:0] c);
    logic [COLOR_W-1:0] r;
    logic [8:0]         s;
    for (int b = 0; b < 4; b++) begin
      s = {1'b0, a[8*b +: 8]} + {1'b0, c[8*b +: 8]};
      r[8*b +: 8] = s[8:1];
    end
    return r;
  endfunction

  function automatic void push_expected(logic [COLOR_W-1:0] up, logic [COLOR_W-1:0] lo,
                                        logic done);
    result_t r;
    r.upper_color = up;
    r.lower_color = lo;
    r.row_done    = done;
    expected_pixels.push_back(r);
  endfunction

  // Applies one accepted transfer to the predictor.
  function automatic void model_item(item_t it);
    logic [COLOR_W-1:0] up;
    logic [COLOR_W-1:0] lo;
    if (it.op == OP_LOAD) begin
      shadow_palette[it.load_bank][it.load_index] = it.load_color;
      if (!entry_written[it.load_bank][it.load_index]) begin
        entry_written[it.load_bank][it.load_index] = 1'b1;
        if (it.load_bank) bank1_entries.push_back(it.load_index);
        else bank0_entries.push_back(it.load_index);
      end
      return;
    end
    up = shadow_palette[sel_bank][it.pixel_upper];
    // progressive: both lines come from the upper index
    lo = interlaced ? shadow_palette[sel_bank][it.pixel_lower] : up;
    if (scan_on) begin
      // odd interlaced field dims the upper line, every other case the lower one
      if (interlaced && odd_field) up = dim_rgb(up);
      else lo = dim_rgb(lo);
    end
    // a held pair always drains against the current pair, whatever blur is now
    if (held_pair) begin
      push_expected(blend_bytes(held_up_color, up), blend_bytes(held_lo_color, lo), 1'b0);
      held_pair = 1'b0;
    end
    if (blur_on && !it.end_of_row) begin
      held_up_color = up;
      held_lo_color = lo;
      held_pair     = 1'b1;
    end else begin
      // row end under blur: last pixel is its own neighbor, so it goes out as is
      push_expected(up, lo, it.end_of_row);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Item builders. Fields the operation does not use get random filler.
  // ---------------------------------------------------------------------------
  function automatic item_t load_item(logic bank, logic [INDEX_W-1:0] idx,
                                      logic [COLOR_W-1:0] color);
    item_t it;
    it.op          = OP_LOAD;
    it.load_bank   = bank;
    it.load_index  = idx;
    it.load_color  = color;
    it.pixel_upper = INDEX_W'($urandom);
    it.pixel_lower = INDEX_W'($urandom);
    it.end_of_row  = 1'($urandom);
    return it;
  endfunction

  function automatic item_t pixel_item(logic [INDEX_W-1:0] up_idx,
                                       logic [INDEX_W-1:0] lo_idx, logic eor);
    item_t it;
    it.op          = OP_PIXEL;
    it.load_bank   = 1'($urandom);
    it.load_index  = INDEX_W'($urandom);
    it.load_color  = $urandom;
    it.pixel_upper = up_idx;
    it.pixel_lower = lo_idx;
    it.end_of_row  = eor;
    return it;
  endfunction

  function automatic logic [INDEX_W-1:0] pick_entry(bit bank);
    if (bank) return bank1_entries[$urandom_range(bank1_entries.size() - 1)];
    return bank0_entries[$urandom_range(bank0_entries.size() - 1)];
  endfunction

  function automatic item_t random_load();
    return load_item(1'($urandom), INDEX_W'($urandom), $urandom);
  endfunction

  // ---------------------------------------------------------------------------
  // Item channel driver. Entered and left on a falling edge; valid stays high
  // after a transfer so back-to-back calls keep it asserted without a glitch.
  // ---------------------------------------------------------------------------
  task automatic send_item(item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    model_item(it);
    items_sent++;
    @(negedge clk);
  endtask

  // Drop valid, wait for every expected result, then let a held or in-flight
  // item settle before any register write.
  task automatic wait_idle();
    item_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // Drives one register write; cfg_we is left high for a following write.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_PALETTE_SELECT:  sel_bank   = val;
      REG_SCANLINE_ENABLE: scan_on    = val;
      REG_BLUR_ENABLE:     blur_on    = val;
      REG_INTERLACE_MODE:  interlaced = val;
      REG_FIELD_ODD:       odd_field  = val;
      default: ;  // no register behind this index
    endcase
    @(negedge clk);
  endtask

  task automatic apply_settings(logic sel, logic scan, logic blur, logic il, logic odd);
    wait_idle();
    write_reg(REG_PALETTE_SELECT, sel);
    write_reg(REG_SCANLINE_ENABLE, scan);
    write_reg(REG_BLUR_ENABLE, blur);
    write_reg(REG_INTERLACE_MODE, il);
    write_reg(REG_FIELD_ODD, odd);
    cfg_we <= 1'b0;
  endtask

  task automatic random_settings();
    case ($urandom_range(3))
      0:       apply_settings(1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      1:       apply_settings(1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
      default: apply_settings(1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                              1'($urandom));
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Result channel: random backpressure and the scoreboard
  // ---------------------------------------------------------------------------
  always @(negedge clk) result_ready <= ($urandom_range(99) >= recv_idle_pct);

  task automatic report_mismatch(string what, logic [COLOR_W-1:0] got,
                                 logic [COLOR_W-1:0] want);
    $display("[%0t] %s: got %h, expected %h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("result transfer with nothing expected", result.upper_color, '0);
      end else begin
        next_expected = expected_pixels.pop_front();
        if (result.upper_color !== next_expected.upper_color)
          report_mismatch("upper_color", result.upper_color, next_expected.upper_color);
        if (result.lower_color !== next_expected.lower_color)
          report_mismatch("lower_color", result.lower_color, next_expected.lower_color);
        if (result.row_done !== next_expected.row_done)
          report_mismatch("row_done", COLOR_W'(result.row_done),
                          COLOR_W'(next_expected.row_done));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset settings: bank 0, no dimming, no blur. Index and color extremes in
  // both banks, then two loads followed directly by a lookup of both entries.
  task automatic test_palette_extremes();
    send_item(load_item(1'b0, '0, 32'h0000_0000));
    send_item(load_item(1'b0, '1, 32'hffff_ffff));
    send_item(load_item(1'b1, '0, 32'ha5a5_a5a5));
    send_item(load_item(1'b1, '1, 32'h5a5a_5a5a));
    send_item(pixel_item('0, '1, 1'b0));
    send_item(pixel_item('1, '0, 1'b1));
    send_item(load_item(1'b0, 15'h2aaa, 32'h0f1e_2d3c));
    send_item(load_item(1'b0, 15'h5555, 32'hf0e1_d2c3));
    send_item(pixel_item(15'h2aaa, 15'h5555, 1'b1));
  endtask

  // Emulation bank with scanlines, every interlace/field combination.
  task automatic test_line_modes();
    apply_settings(1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
    send_item(pixel_item('0, '1, 1'b1));
    apply_settings(1'b1, 1'b1, 1'b0, 1'b1, 1'b0);
    send_item(pixel_item('0, '1, 1'b1));
    apply_settings(1'b1, 1'b1, 1'b0, 1'b1, 1'b1);
    send_item(pixel_item('1, '0, 1'b1));
    // field bit must not matter when progressive
    apply_settings(1'b1, 1'b1, 1'b0, 1'b0, 1'b1);
    send_item(pixel_item('1, '0, 1'b1));
  endtask

  task automatic test_blur_rows();
    apply_settings(1'b0, 1'b1, 1'b1, 1'b1, 1'b1);
    // one-pixel row: nothing held, single result with row_done
    send_item(pixel_item('1, '0, 1'b1));
    // three-pixel row: flush emits two results on the last transfer
    send_item(pixel_item('0, '1, 1'b0));
    send_item(pixel_item(15'h2aaa, 15'h5555, 1'b0));
    send_item(pixel_item('1, 15'h2aaa, 1'b1));
    // leave a pair held, then turn blur off underneath it
    send_item(pixel_item(15'h5555, '0, 1'b0));
    send_item(pixel_item('1, '1, 1'b0));
    apply_settings(1'b0, 1'b1, 1'b0, 1'b1, 1'b1);
    send_item(pixel_item('0, 15'h2aaa, 1'b0));
  endtask

  // Writes to indexes with no register behind them must change nothing.
  task automatic test_unused_reg_index();
    wait_idle();
    for (int i = REG_FIELD_ODD + 1; i < (1 << CFG_IDX_W); i++)
      write_reg(CFG_IDX_W'(i), 1'b1);
    cfg_we <= 1'b0;
    send_item(pixel_item('0, '1, 1'b1));
  endtask

  // Mostly well-formed rows with random content; loose palette loads, rows
  // that lose their end marker, and register changes at random points,
  // including with a blur pair held.
  task automatic test_random_traffic();
    int target;
    int row_len;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 16;
          recv_idle_pct = 85;
        end
        1: begin
          send_idle_pct = 85;
          recv_idle_pct = 16;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      target = items_sent + RANDOM_ITEMS;
      while (items_sent < target) begin
        if ($urandom_range(7) == 0) random_settings();
        if ($urandom_range(5) == 0) begin
          repeat ($urandom_range(1, 4)) send_item(random_load());
        end else begin
          row_len = $urandom_range(1, 10);
          for (int k = 0; k < row_len; k++) begin
            if ($urandom_range(9) == 0) send_item(random_load());
            // roughly one row in fifteen never gets its end marker
            send_item(pixel_item(pick_entry(sel_bank), pick_entry(sel_bank),
                                 (k == row_len - 1) && ($urandom_range(14) != 0)));
          end
        end
        // sender holds off until the block has drained
        if ($urandom_range(19) == 0) wait_idle();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    item_valid    = 1'b0;
    item          = '0;
    result_ready  = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    rst           = 1'b1;
    mismatches    = 0;
    items_sent    = 0;
    cycle_count   = 0;
    send_idle_pct = 16;
    recv_idle_pct = 85;
    held_pair     = 1'b0;
    held_up_color = '0;
    held_lo_color = '0;
    sel_bank      = 1'b0;
    scan_on       = 1'b0;
    blur_on       = 1'b0;
    interlaced    = 1'b0;
    odd_field     = 1'b0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_palette_extremes();
    test_line_modes();
    test_blur_rows();
    test_unused_reg_index();
    test_random_traffic();

    wait_idle();
    if (mismatches == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
